>>> hw/rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and helpers for the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int unsigned CW = 36;  // CORDIC datapath width, Q2.30 plus headroom

    localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sh026DD3B6A;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    function automatic logic signed [CW-1:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        begin
            unique case (i)
                0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
                2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
                4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
                6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
                8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
                10: v = 32'h000A2F98;  11: v = 32'h000517CC;
                12: v = 32'h00028BE6;  13: v = 32'h000145F3;
                14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
                16: v = 32'h000028BE;  17: v = 32'h0000145F;
                18: v = 32'h00000A30;  19: v = 32'h00000518;
                20: v = 32'h0000028C;  21: v = 32'h00000146;
                22: v = 32'h000000A3;  23: v = 32'h00000051;
                24: v = 32'h00000029;  25: v = 32'h00000014;
                26: v = 32'h0000000A;  27: v = 32'h00000005;
                28: v = 32'h00000003;  29: v = 32'h00000001;
                30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_turn = $signed({4'b0000, v});
        end
    endfunction

    // Q2.30 product, rounded half up; operands lie within +-2
    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        begin
            p = a * b + (72'sd1 <<< 29);
            mul_q30 = CW'(p >>> 30);
        end
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
    } t_sc;

endpackage

>>> hw/rtl/e2q_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channel carrying a payload of configurable width.
// ----------------------------------------------------------------------------
interface e2q_if #(
    parameter int unsigned W = 48
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation CORDIC: sine and cosine of a half angle, one step/stage.
// ----------------------------------------------------------------------------
module e2q_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [31:0]    i_half,
    output e2q_pkg::t_sc   o_sc
);
    localparam int unsigned CW = e2q_pkg::CW;

    logic signed [CW-1:0] r_x [STEPS+1];
    logic signed [CW-1:0] r_y [STEPS+1];
    logic signed [CW-1:0] r_z [STEPS+1];
    logic                 r_up [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_up[0] <= i_half >= e2q_pkg::QUARTER_TURN;
            r_z[0]  <= (i_half >= e2q_pkg::QUARTER_TURN)
                ? $signed({4'b0000, i_half - e2q_pkg::QUARTER_TURN})
                : $signed({4'b0000, i_half});
            r_x[0]  <= e2q_pkg::CORDIC_GAIN;
            r_y[0]  <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_up[i+1] <= r_up[i];
                if (!r_z[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - e2q_pkg::atan_turn(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + e2q_pkg::atan_turn(i);
                end
            end
        end
    end

    always_comb begin
        if (r_up[STEPS]) begin
            o_sc.s = r_x[STEPS];
            o_sc.c = -r_y[STEPS];
        end else begin
            o_sc.s = r_y[STEPS];
            o_sc.c = r_x[STEPS];
        end
    end
endmodule

>>> hw/rtl/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Three-stage product tree and output rounding/saturation.
// ----------------------------------------------------------------------------
module e2q_combine #(
    parameter int unsigned COMPONENT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  e2q_pkg::t_sc              i_x,
    input  e2q_pkg::t_sc              i_y,
    input  e2q_pkg::t_sc              i_z,
    output logic [4*COMPONENT_BITS-1:0] o_q
);
    localparam int unsigned CW = e2q_pkg::CW;
    localparam int unsigned FR = COMPONENT_BITS - 1;
    localparam int unsigned SW = CW + 4;

    logic signed [CW-1:0] r_cxcy, r_sxsy, r_sxcy, r_cxsy;
    e2q_pkg::t_sc         r_z1;
    logic signed [CW-1:0] r_p [8];
    logic signed [SW-1:0] r_sum [4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cxcy <= e2q_pkg::mul_q30(i_x.c, i_y.c);
            r_sxsy <= e2q_pkg::mul_q30(i_x.s, i_y.s);
            r_sxcy <= e2q_pkg::mul_q30(i_x.s, i_y.c);
            r_cxsy <= e2q_pkg::mul_q30(i_x.c, i_y.s);
            r_z1   <= i_z;
            r_p[0] <= e2q_pkg::mul_q30(r_sxcy, r_z1.c);
            r_p[1] <= e2q_pkg::mul_q30(r_cxsy, r_z1.s);
            r_p[2] <= e2q_pkg::mul_q30(r_cxsy, r_z1.c);
            r_p[3] <= e2q_pkg::mul_q30(r_sxcy, r_z1.s);
            r_p[4] <= e2q_pkg::mul_q30(r_cxcy, r_z1.s);
            r_p[5] <= e2q_pkg::mul_q30(r_sxsy, r_z1.c);
            r_p[6] <= e2q_pkg::mul_q30(r_cxcy, r_z1.c);
            r_p[7] <= e2q_pkg::mul_q30(r_sxsy, r_z1.s);
            r_sum[0] <= SW'(r_p[0]) - SW'(r_p[1]);
            r_sum[1] <= SW'(r_p[2]) + SW'(r_p[3]);
            r_sum[2] <= SW'(r_p[4]) - SW'(r_p[5]);
            r_sum[3] <= SW'(r_p[6]) + SW'(r_p[7]);
        end
    end

    localparam logic signed [SW+2:0] MAXV = (SW+3)'((64'sd1 <<< FR) - 1);
    localparam logic signed [SW+2:0] MINV = -MAXV - 1;

    for (genvar k = 0; k < 4; k++) begin : g_out
        logic signed [SW+2:0] v;
        always_comb begin
            if (FR <= 30)
                v = ((SW+3)'(r_sum[k]) + (((SW+3)'(1) <<< (30 - FR)) >>> 1)) >>> (30 - FR);
            else
                v = (SW+3)'(r_sum[k]) <<< (FR - 30);
            if (v > MAXV)      o_q[k*COMPONENT_BITS +: COMPONENT_BITS] = MAXV[COMPONENT_BITS-1:0];
            else if (v < MINV) o_q[k*COMPONENT_BITS +: COMPONENT_BITS] = MINV[COMPONENT_BITS-1:0];
            else               o_q[k*COMPONENT_BITS +: COMPONENT_BITS] = v[COMPONENT_BITS-1:0];
        end
    end
endmodule

>>> hw/rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angles (X, Y, Z binary angles) to rotation quaternion, Q1.15 output.
// ----------------------------------------------------------------------------
// Fully pipelined: accepts one transaction per cycle while the pipeline
// advances. STEPS is CORDIC_STEPS capped at 32. The angle stage loads at the
// accepting edge; then follow one stage per CORDIC step, three product/sum
// stages and the output register. The whole pipeline advances when the
// output register is empty or being drained. Input data is
// {angle_z, angle_y, angle_x}; output is {quat_w, quat_z, quat_y, quat_x}.
module euler_to_quaternion #(
    parameter int unsigned ANGLE_BITS     = 16,
    parameter int unsigned COMPONENT_BITS = 16,
    parameter int unsigned CORDIC_STEPS   = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    e2q_if.sink   i_in,
    e2q_if.source o_out
);
    localparam int unsigned STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int unsigned DEPTH = STEPS + 4;

    logic                        w_en;
    logic [DEPTH-1:0]            r_vld;
    logic                        r_ovld;
    logic [4*COMPONENT_BITS-1:0] r_odata;
    logic [4*COMPONENT_BITS-1:0] w_q;
    logic [31:0]                 w_half [3];
    e2q_pkg::t_sc                w_sc [3];

    assign w_en       = !r_ovld || o_out.ready;
    assign i_in.ready = w_en;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [ANGLE_BITS-1:0] w_ang;
        logic [31:0]           w_p;
        assign w_ang = i_in.data[a*ANGLE_BITS +: ANGLE_BITS];
        if (ANGLE_BITS <= 32) begin : g_sh
            assign w_p = 32'(w_ang) << (32 - ANGLE_BITS);
        end else begin : g_tr
            assign w_p = w_ang[ANGLE_BITS-1 -: 32];
        end
        assign w_half[a] = w_p >> 1;
        e2q_cordic #(.STEPS(STEPS)) u_cordic (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_half (w_half[a]),
            .o_sc   (w_sc[a])
        );
    end

    e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_combine (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_sc[0]),
        .i_y   (w_sc[1]),
        .i_z   (w_sc[2]),
        .o_q   (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[DEPTH-2:0], i_in.valid};
            r_ovld <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= w_q;
        end
    end

    assign o_out.valid = r_ovld;
    assign o_out.data  = r_odata;
endmodule
